FILE: sv/arst_pkg.sv
// Shared types and constants of the address range set table.
`timescale 1ns / 1ps
package arst_pkg;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_DEL    = 2'd1,
    ACT_LOOKUP = 2'd2,
    ACT_NONE   = 2'd3
  } act_t;

  typedef struct packed {
    act_t        action;
    logic [31:0] base_address;
    logic [31:0] length;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] range_begin;
    logic        status;
  } rsp_t;

  // Which entry is pushed in at the edit point.
  typedef enum logic [1:0] {
    INS_MERGED = 2'd0,
    INS_RIGHT  = 2'd1,
    INS_LEFT   = 2'd2
  } ins_t;

  typedef struct packed {
    logic load;
    logic calc_end;
    logic scan;
    logic shl;
    logic shr;
    ins_t ins_sel;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic nop;
    logic rem_zero;
    logic is_add;
    logic need_right;
    logic need_left;
  } stat_t;

  localparam logic [32:0] ADDR_LIMIT = 33'h1_0000_0000;

endpackage

FILE: sv/address_range_set_table_unit.sv
// Top level of the address range set table: controller, datapath, result register.
//
//   Channel | Ports                          | Carries
//   --------+--------------------------------+------------------------------------
//   input   | in_valid, in_ready, in_req     | action, base_address, length
//   result  | out_valid, out_ready, out_rsp  | hit, range_begin, status
//
// A lookup, an unused action, a zero length or a dropped request goes from acceptance
// through the end, scan and decide states to the result register; an add or a delete
// first removes each stored range it absorbs or cuts, cells shifting one place per
// cycle to close and open gaps; a new request is taken in the cycle after the finish.
// Reset clears the range count and the controller; the table then reads empty.
// A result waits in its own register, so a new request is taken meanwhile and
// only its completion stalls while the previous result is not yet taken.
`timescale 1ns / 1ps
module address_range_set_table_unit #(
  parameter int MAX_RANGES = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  arst_pkg::req_t in_req,
  output logic           out_valid,
  input  logic           out_ready,
  output arst_pkg::rsp_t out_rsp
);

  arst_pkg::cmd_t  cmd;
  arst_pkg::stat_t stat;
  arst_pkg::rsp_t  rsp;
  arst_pkg::rsp_t  out_rsp_r;
  logic            out_valid_r, out_valid_nxt;
  logic            out_free;

  // The result slot can take a new result when empty or being drained now.
  assign out_free = !out_valid_r || out_ready;

  arst_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_free (out_free),
    .stat     (stat),
    .cmd      (cmd)
  );

  arst_dp #(
    .MAX_RANGES (MAX_RANGES)
  ) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (in_req),
    .cmd    (cmd),
    .stat   (stat),
    .rsp    (rsp)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_rsp_r <= rsp;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

endmodule

FILE: sv/arst_dp.sv
// Datapath of the range table: cell array, parallel compares and shifting.
`timescale 1ns / 1ps
module arst_dp #(
  parameter int MAX_RANGES = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  arst_pkg::req_t in_req,
  input  arst_pkg::cmd_t cmd,
  output arst_pkg::stat_t stat,
  output arst_pkg::rsp_t  rsp
);

  localparam int CW = $clog2(MAX_RANGES + 1);

  arst_pkg::req_t  req_r;
  logic [32:0]     e_r;
  logic [31:0]     start_r [MAX_RANGES];
  logic [32:0]     stop_r  [MAX_RANGES];
  logic [MAX_RANGES-1:0] keep_r, ovl_r;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            hit_r, full_r, nl_r, nr_r;
  logic [31:0]     begin_r, mb_r, ls_r;
  logic [32:0]     me_r, rt_r;

  logic [32:0]     sum;
  logic            is_add, is_del, is_lk, any_ovl, nl, nr, full_add, full_del, cnt_full;
  logic [MAX_RANGES-1:0] vld, below, ov, lk, first, last;
  logic [31:0]     s_first, lk_begin, mb, ins_start;
  logic [32:0]     t_last, me, ins_stop, b33;

  assign is_add = (req_r.action == arst_pkg::ACT_ADD);
  assign is_del = (req_r.action == arst_pkg::ACT_DEL);
  assign is_lk  = (req_r.action == arst_pkg::ACT_LOOKUP);
  assign b33    = {1'b0, req_r.base_address};
  assign sum    = b33 + {1'b0, req_r.length};
  assign cnt_full = (cnt_r == CW'(MAX_RANGES));

  // Every cell compares itself against the request at once.
  always_comb begin
    for (int i = 0; i < MAX_RANGES; i++) begin
      vld[i] = (CW'(i) < cnt_r);
      if (is_add) begin
        below[i] = vld[i] && (stop_r[i] < b33);
        ov[i]    = vld[i] && (stop_r[i] >= b33) && ({1'b0, start_r[i]} <= e_r);
      end else begin
        below[i] = vld[i] && (stop_r[i] <= b33);
        ov[i]    = vld[i] && (stop_r[i] > b33) && ({1'b0, start_r[i]} < e_r);
      end
      lk[i] = vld[i] && (start_r[i] <= req_r.base_address) && (b33 < stop_r[i]);
    end
  end

  assign first = ov & ~{ov[MAX_RANGES-2:0], 1'b0};
  assign last  = ov & ~{1'b0, ov[MAX_RANGES-1:1]};

  always_comb begin
    s_first  = '0;
    t_last   = '0;
    lk_begin = '0;
    for (int i = 0; i < MAX_RANGES; i++) begin
      s_first  = s_first  | (first[i] ? start_r[i] : 32'd0);
      t_last   = t_last   | (last[i]  ? stop_r[i]  : 33'd0);
      lk_begin = lk_begin | (lk[i]    ? start_r[i] : 32'd0);
    end
  end

  assign any_ovl  = |ov;
  assign nl       = any_ovl && (s_first < req_r.base_address);
  assign nr       = any_ovl && (t_last > e_r);
  assign mb       = nl ? s_first : req_r.base_address;
  assign me       = nr ? t_last : e_r;
  assign full_add = !any_ovl && cnt_full;
  // A split grows the table only when one entry holds the whole hole.
  assign full_del = nl && nr && (|(first & last)) && cnt_full;

  always_comb begin
    case (cmd.ins_sel)
      arst_pkg::INS_RIGHT: begin
        ins_start = e_r[31:0];
        ins_stop  = rt_r;
      end
      arst_pkg::INS_LEFT: begin
        ins_start = ls_r;
        ins_stop  = b33;
      end
      default: begin
        ins_start = mb_r;
        ins_stop  = me_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_req;
    end
    if (cmd.calc_end) begin
      e_r <= (sum > arst_pkg::ADDR_LIMIT) ? arst_pkg::ADDR_LIMIT : sum;
    end
    if (cmd.scan) begin
      keep_r  <= below;
      ovl_r   <= ov;
      hit_r   <= is_lk && (|lk);
      begin_r <= is_lk ? lk_begin : 32'd0;
      full_r  <= (req_r.length != 32'd0) && ((is_add && full_add) || (is_del && full_del));
      nl_r    <= nl;
      nr_r    <= nr;
      mb_r    <= mb;
      me_r    <= me;
      ls_r    <= s_first;
      rt_r    <= t_last;
    end else if (cmd.shl) begin
      ovl_r <= (ovl_r >> 1) & ~keep_r;
    end
  end

  for (genvar i = 0; i < MAX_RANGES; i++) begin : g_cell
    always_ff @(posedge clk) begin
      if (cmd.shl && !keep_r[i]) begin
        if (i < MAX_RANGES - 1) begin
          start_r[i] <= start_r[(i + 1) % MAX_RANGES];
          stop_r[i]  <= stop_r[(i + 1) % MAX_RANGES];
        end
      end else if (cmd.shr && !keep_r[i]) begin
        if (i == 0 || keep_r[(i + MAX_RANGES - 1) % MAX_RANGES]) begin
          start_r[i] <= ins_start;
          stop_r[i]  <= ins_stop;
        end else begin
          start_r[i] <= start_r[(i + MAX_RANGES - 1) % MAX_RANGES];
          stop_r[i]  <= stop_r[(i + MAX_RANGES - 1) % MAX_RANGES];
        end
      end
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.shl) begin
      cnt_nxt = cnt_r - CW'(1);
    end else if (cmd.shr) begin
      cnt_nxt = cnt_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  assign stat.nop        = is_lk || (req_r.action == arst_pkg::ACT_NONE) ||
                           (req_r.length == 32'd0) || full_r;
  assign stat.rem_zero   = ~|ovl_r;
  assign stat.is_add     = is_add;
  assign stat.need_right = nr_r;
  assign stat.need_left  = nl_r;

  assign rsp.hit         = hit_r;
  assign rsp.range_begin = begin_r;
  assign rsp.status      = full_r;

endmodule

FILE: sv/arst_ctrl.sv
// Controller state machine that sequences one request through the datapath.
`timescale 1ns / 1ps
module arst_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            out_free,
  input  arst_pkg::stat_t stat,
  output arst_pkg::cmd_t  cmd
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_END    = 8'b0000_0010,
    S_SCAN   = 8'b0000_0100,
    S_DECIDE = 8'b0000_1000,
    S_REM    = 8'b0001_0000,
    S_INS1   = 8'b0010_0000,
    S_INS2   = 8'b0100_0000,
    S_FIN    = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.ins_sel = arst_pkg::INS_MERGED;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_END;
        end
      end
      S_END: begin
        cmd.calc_end = 1'b1;
        state_nxt    = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan  = 1'b1;
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        state_nxt = stat.nop ? S_FIN : S_REM;
      end
      S_REM: begin
        if (stat.rem_zero) begin
          state_nxt = S_INS1;
        end else begin
          cmd.shl = 1'b1;
        end
      end
      S_INS1: begin
        if (stat.is_add) begin
          cmd.shr = 1'b1;
        end else if (stat.need_right) begin
          cmd.shr     = 1'b1;
          cmd.ins_sel = arst_pkg::INS_RIGHT;
        end
        state_nxt = S_INS2;
      end
      S_INS2: begin
        if (!stat.is_add && stat.need_left) begin
          cmd.shr     = 1'b1;
          cmd.ins_sel = arst_pkg::INS_LEFT;
        end
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for the address range set table: directed and random requests.
`timescale 1ns / 1ps
module testbench;
  import arst_pkg::*;

  localparam int TABLE_DEPTH = 16;
  localparam int RUN_LIMIT = 400000;
  localparam logic [32:0] SPACE_END = 33'h1_0000_0000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  req_t in_req;
  logic out_valid;
  logic out_ready;
  rsp_t out_rsp;

  address_range_set_table_unit #(.MAX_RANGES(TABLE_DEPTH)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_req(in_req),
    .out_valid(out_valid), .out_ready(out_ready), .out_rsp(out_rsp)
  );

  // Clock with a 12 ns period.
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow copy of the range table, kept sorted and disjoint.
  logic [32:0] shadow_start [TABLE_DEPTH];
  logic [32:0] shadow_stop [TABLE_DEPTH];
  int shadow_count;

  rsp_t pending_rsp [$];
  int error_count;
  int request_count;
  int response_count;
  int hit_count;
  int full_count;
  int cycle_count;

  // Computes the response and updates the shadow table for one request.
  function automatic rsp_t apply_request(req_t req);
    rsp_t rsp;
    logic [32:0] lo;
    logic [32:0] hi;
    logic [32:0] mlo;
    logic [32:0] mhi;
    logic [32:0] ns [TABLE_DEPTH + 2];
    logic [32:0] ne [TABLE_DEPTH + 2];
    int n;
    int touched;
    bit placed;
    rsp = '0;
    lo = {1'b0, req.base_address};
    hi = lo + {1'b0, req.length};
    if (hi > SPACE_END) hi = SPACE_END;
    n = 0;
    case (req.action)
      ACT_ADD: begin
        if (req.length != 0) begin
          touched = 0;
          mlo = lo;
          mhi = hi;
          for (int i = 0; i < shadow_count; i++) begin
            if (shadow_stop[i] >= lo && shadow_start[i] <= hi) begin
              touched++;
              if (shadow_start[i] < mlo) mlo = shadow_start[i];
              if (shadow_stop[i] > mhi) mhi = shadow_stop[i];
            end
          end
          if (touched == 0 && shadow_count >= TABLE_DEPTH) begin
            rsp.status = 1'b1;
          end else begin
            placed = 0;
            for (int i = 0; i < shadow_count; i++) begin
              if (shadow_stop[i] < lo) begin
                ns[n] = shadow_start[i]; ne[n] = shadow_stop[i]; n++;
              end else if (shadow_start[i] > hi) begin
                if (!placed) begin
                  ns[n] = mlo; ne[n] = mhi; n++; placed = 1;
                end
                ns[n] = shadow_start[i]; ne[n] = shadow_stop[i]; n++;
              end
            end
            if (!placed) begin
              ns[n] = mlo; ne[n] = mhi; n++;
            end
            for (int i = 0; i < n; i++) begin
              shadow_start[i] = ns[i]; shadow_stop[i] = ne[i];
            end
            shadow_count = n;
          end
        end
      end
      ACT_DEL: begin
        if (req.length != 0) begin
          for (int i = 0; i < shadow_count; i++) begin
            if (shadow_stop[i] <= lo || shadow_start[i] >= hi) begin
              ns[n] = shadow_start[i]; ne[n] = shadow_stop[i]; n++;
            end else begin
              if (shadow_start[i] < lo) begin
                ns[n] = shadow_start[i]; ne[n] = lo; n++;
              end
              if (shadow_stop[i] > hi) begin
                ns[n] = hi; ne[n] = shadow_stop[i]; n++;
              end
            end
          end
          // A single delete grows the table by at most one entry.
          if (n > TABLE_DEPTH) begin
            rsp.status = 1'b1;
          end else begin
            for (int i = 0; i < n; i++) begin
              shadow_start[i] = ns[i]; shadow_stop[i] = ne[i];
            end
            shadow_count = n;
          end
        end
      end
      ACT_LOOKUP: begin
        for (int i = 0; i < shadow_count; i++) begin
          if (lo < shadow_start[i]) break;
          if (lo < shadow_stop[i]) begin
            rsp.hit = 1'b1;
            rsp.range_begin = shadow_start[i][31:0];
            break;
          end
        end
      end
      default: ;
    endcase
    return rsp;
  endfunction

  // Sends one request, holding it until the block accepts it; random gaps in bursts.
  // Valid stays high into the next request of a burst and drops only for a gap.
  int burst_left;
  task automatic send_request(act_t act, logic [31:0] base, logic [31:0] len);
    req_t req;
    req.action = act;
    req.base_address = base;
    req.length = len;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 2) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    burst_left--;
    in_req <= req;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_rsp.push_back(apply_request(req));
    request_count++;
  endtask

  // Waits until every outstanding response has come back and the block is settled.
  task automatic drain;
    in_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  // Receiver stall pattern: alternating free and busy stretches of random length.
  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 25)) @(posedge clk);
      if ($urandom_range(0, 3) != 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
    end
  end

  // Compares each accepted response against the oldest expected one.
  always @(posedge clk) begin
    rsp_t want;
    if (rst_n && out_valid && out_ready) begin
      response_count++;
      if (pending_rsp.size() == 0) begin
        $display("%0t: unexpected response hit=%0b begin=%h status=%0b", $time,
                 out_rsp.hit, out_rsp.range_begin, out_rsp.status);
        error_count++;
      end else begin
        want = pending_rsp.pop_front();
        if (want.hit) hit_count++;
        if (want.status) full_count++;
        if (out_rsp.hit !== want.hit) begin
          $display("%0t: hit expected %0b actual %0b", $time, want.hit, out_rsp.hit);
          error_count++;
        end
        if (out_rsp.range_begin !== want.range_begin) begin
          $display("%0t: range_begin expected %h actual %h", $time,
                   want.range_begin, out_rsp.range_begin);
          error_count++;
        end
        if (out_rsp.status !== want.status) begin
          $display("%0t: status expected %0b actual %0b", $time,
                   want.status, out_rsp.status);
          error_count++;
        end
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > RUN_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Probes the addresses right before, at and after the given address.
  task automatic probe_around(logic [31:0] addr);
    send_request(ACT_LOOKUP, addr - 1, $urandom);
    send_request(ACT_LOOKUP, addr, $urandom);
    send_request(ACT_LOOKUP, addr + 1, $urandom);
  endtask

  // Zero length, touching merges, split, saturated end, unused action.
  task automatic test_directed;
    send_request(ACT_LOOKUP, 32'h0, 32'h0);
    send_request(ACT_ADD, 32'h1000, 32'h0);
    send_request(ACT_ADD, 32'h1000, 32'h100);
    send_request(ACT_ADD, 32'h1100, 32'h100);
    send_request(ACT_ADD, 32'h0F00, 32'h100);
    probe_around(32'h0F00);
    send_request(ACT_DEL, 32'h1080, 32'h10);
    send_request(ACT_LOOKUP, 32'h1090, 32'h0);
    send_request(ACT_DEL, 32'h1000, 32'h0);
    send_request(ACT_ADD, 32'hFFFF_FF00, 32'hFFFF_FFFF);
    send_request(ACT_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(ACT_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(ACT_DEL, 32'h0, 32'hFFFF_FFFF);
    send_request(ACT_LOOKUP, 32'hFFFF_FFFF, 32'h0);
    send_request(ACT_DEL, 32'hFFFF_FFFF, 32'h1);
    send_request(ACT_LOOKUP, 32'hFFFF_FFFF, 32'h0);
    send_request(ACT_ADD, 32'h0, 32'hFFFF_FFFF);
    send_request(ACT_DEL, 32'h0, 32'hFFFF_FFFF);
    drain();
  endtask

  // Fills the table, then forces the add-full and split-full cases.
  task automatic test_full_table;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      send_request(ACT_ADD, 32'h10_0000 * i, 32'h1000);
    end
    send_request(ACT_ADD, 32'h0F00_0000, 32'h10);
    send_request(ACT_DEL, 32'h10_0100, 32'h10);
    send_request(ACT_ADD, 32'h10_1000, 32'h10);
    send_request(ACT_DEL, 32'h0, 32'hFFFF_FFFF);
    drain();
  endtask

  // Random requests in a given window; a small window makes ranges merge, split and fill up often.
  task automatic test_random_window(int count, logic [31:0] window);
    act_t act;
    logic [31:0] base;
    logic [31:0] len;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: act = ACT_ADD;
        4, 5, 6:    act = ACT_DEL;
        7, 8:       act = ACT_LOOKUP;
        default:    act = ACT_NONE;
      endcase
      base = $urandom_range(0, window);
      len = $urandom_range(0, 15) == 0 ? 32'h0 : $urandom_range(1, window / 8);
      if ($urandom_range(0, 7) == 0) base = ~base;
      if ($urandom_range(0, 15) == 0) len = $urandom;
      if ($urandom_range(0, 19) == 0 && shadow_count != 0) begin
        base = shadow_start[$urandom_range(0, shadow_count - 1)][31:0];
      end
      send_request(act, base, len);
    end
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req = '0;
    shadow_count = 0;
    error_count = 0;
    request_count = 0;
    response_count = 0;
    hit_count = 0;
    full_count = 0;
    cycle_count = 0;
    burst_left = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_full_table();
    test_random_window(500, 32'h400);
    test_random_window(400, 32'h4000);
    test_random_window(200, 32'hFFFF_FFFF);
    $display("Covered %0d requests: %0d lookup hits, %0d table-full drops.",
             request_count, hit_count, full_count);
    if (error_count == 0 && pending_rsp.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/arst_pkg.sv
sv/arst_dp.sv
sv/arst_ctrl.sv
sv/address_range_set_table_unit.sv
tb/sv/testbench.sv
